[rtl/core/jbnc_pkg.sv]
// Package: constants, types and helpers for the JSON bracket nesting checker.
`default_nettype none
package jbnc_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
	localparam int DEPTH_W   = 7;
	localparam int WIDE_W    = CNT_W + DEPTH_W;

	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_OPEN_SQ  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQ = 8'h5D;
	localparam logic [7:0] CH_OPEN_CU  = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CU = 8'h7D;

	localparam logic KIND_SQ = 1'b0;
	localparam logic KIND_CU = 1'b1;

	localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(MAX_DEPTH);
	localparam logic [WIDE_W-1:0]  DEPTH_SAT = WIDE_W'((1 << DEPTH_W) - 1);

	typedef struct packed {
		logic                mismatch;
		logic                overflow;
		logic [DEPTH_W-1:0]  nest_depth;
		logic                inside_string;
		logic                doc_end;
	} status_t;

	function automatic logic [DEPTH_W-1:0] sat_depth(input logic [CNT_W-1:0] cnt);
		logic [WIDE_W-1:0] wide;
		wide = {{DEPTH_W{1'b0}}, cnt};
		if (wide > DEPTH_SAT)
			wide = DEPTH_SAT;
		return wide[DEPTH_W-1:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/jbnc_if.sv]
// Interfaces: byte input channel and status output channel.
`default_nettype none
interface jbnc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface jbnc_out_if;
	logic       valid;
	logic       ready;
	logic       mismatch;
	logic       overflow;
	logic [6:0] nest_depth;
	logic       inside_string;
	logic       doc_end;

	modport source (output valid, output mismatch, output overflow, output nest_depth,
		output inside_string, output doc_end, input ready);
	modport sink   (input valid, input mismatch, input overflow, input nest_depth,
		input inside_string, input doc_end, output ready);
endinterface
`default_nettype wire

[rtl/core/json_bracket_nesting_checker.sv]
// Top level: JSON bracket nesting checker.
// The status for a byte is registered at its transfer and is valid in the cycle after.
// Throughput: one byte per cycle while the sink takes each status; the tracker state updates in the transfer cycle.
// Input is ready whenever the status register is empty or being taken.
// Reset clears count, string and sticky flags; stack contents are not reset.
// State also clears after the transfer of a byte marked last.
`default_nettype none
module json_bracket_nesting_checker
	import jbnc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	jbnc_in_if.sink    in_ch,
	jbnc_out_if.source out_ch
);

	logic    can_take;
	logic    take;
	status_t status;

	assign in_ch.ready = can_take;
	assign take        = in_ch.valid && can_take;

	jbnc_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_in   (in_ch.byte_in),
		.last_byte (in_ch.last_byte),
		.status    (status)
	);

	jbnc_ostage u_ostage (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.status   (status),
		.can_take (can_take),
		.out_ch   (out_ch)
	);

endmodule
`default_nettype wire

[rtl/core/jbnc_track.sv]
// Bracket tracker: string flag, shift-register stack, count and sticky flags.
`default_nettype none
module jbnc_track
	import jbnc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  byte_in,
	input  wire logic        last_byte,
	output status_t          status
);

	logic [MAX_DEPTH-1:0] stack_q;
	logic [CNT_W-1:0]     count_q;
	logic                 str_q;
	logic                 mis_q;
	logic                 ovf_q;

	logic [MAX_DEPTH-1:0] stack_d;
	logic [CNT_W-1:0]     count_d;
	logic                 str_d;
	logic                 mis_d;
	logic                 ovf_d;
	logic                 is_open;
	logic                 is_close;
	logic                 kind;

	always_comb begin
		stack_d  = stack_q;
		count_d  = count_q;
		str_d    = str_q;
		mis_d    = mis_q;
		ovf_d    = ovf_q;
		is_open  = (byte_in == CH_OPEN_SQ) || (byte_in == CH_OPEN_CU);
		is_close = (byte_in == CH_CLOSE_SQ) || (byte_in == CH_CLOSE_CU);
		kind     = (byte_in == CH_OPEN_CU) || (byte_in == CH_CLOSE_CU) ? KIND_CU : KIND_SQ;
		if (byte_in == CH_QUOTE) begin
			str_d = !str_q;
		end else if (!str_q) begin
			if (is_open) begin
				if (count_q == CNT_FULL) begin
					ovf_d = 1'b1;
				end else begin
					stack_d = {stack_q[MAX_DEPTH-2:0], kind};
					count_d = count_q + CNT_W'(1);
				end
			end else if (is_close) begin
				if (count_q == '0 || stack_q[0] != kind) begin
					mis_d = 1'b1;
				end else begin
					stack_d = {1'b0, stack_q[MAX_DEPTH-1:1]};
					count_d = count_q - CNT_W'(1);
				end
			end
		end
		status.mismatch      = mis_d;
		status.overflow      = ovf_d;
		status.nest_depth    = sat_depth(count_d);
		status.inside_string = str_d;
		status.doc_end       = last_byte;
	end

	always_ff @(posedge clk) begin
		if (take)
			stack_q <= stack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			str_q   <= 1'b0;
			mis_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				count_q <= '0;
				str_q   <= 1'b0;
				mis_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_d;
				str_q   <= str_d;
				mis_q   <= mis_d;
				ovf_q   <= ovf_d;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/jbnc_ostage.sv]
// Output stage: status register with valid/ready toward the sink.
`default_nettype none
module jbnc_ostage
	import jbnc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      take,
	input  wire status_t   status,
	output logic           can_take,
	jbnc_out_if.source     out_ch
);

	logic    valid_q;
	status_t stat_q;

	assign can_take = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			stat_q <= status;
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.mismatch      = stat_q.mismatch;
	assign out_ch.overflow      = stat_q.overflow;
	assign out_ch.nest_depth    = stat_q.nest_depth;
	assign out_ch.inside_string = stat_q.inside_string;
	assign out_ch.doc_end       = stat_q.doc_end;

endmodule
`default_nettype wire
